// File: rtl/amm_pkg.sv
// ============================================================================
// amm_pkg - shared types and constants of the matrix audio mixer
// Field widths, command codes, sequencer states and the bundles that pass
// between the sequencer and the gain bank.
// ============================================================================
`default_nettype none

package amm_pkg;

    // Fixed field widths
    localparam int IDX_W    = 3;   // channel index fields
    localparam int GAIN_W   = 16;  // unsigned gain
    localparam int SAMPLE_W = 24;  // signed audio sample
    localparam int ACC_W    = 32;  // mix accumulator
    localparam int MAX_CH   = 8;   // channels reachable through a 3-bit index

    // Shared multiplier: signed 32-bit operand times unsigned 16-bit gain
    localparam int MUL_A_W  = 32;
    localparam int PROD_W   = MUL_A_W + GAIN_W;

    // Stream packing
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;

    // Item function codes (tuser bit 0)
    localparam logic FUNC_GAIN   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Gain kind codes (tuser bits 2:1); the fourth code is ignored
    localparam logic [1:0] KIND_INPUT  = 2'd0;
    localparam logic [1:0] KIND_XPOINT = 2'd1;
    localparam logic [1:0] KIND_OUTPUT = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_LOAD,
        ST_XMUL,
        ST_XACC,
        ST_OMUL,
        ST_EMIT
    } amm_state_t;

    // Gain write request
    typedef struct packed {
        logic              en;
        logic [1:0]        kind;
        logic [IDX_W-1:0]  in_idx;
        logic [IDX_W-1:0]  out_idx;
        logic [GAIN_W-1:0] value;
    } gain_wr_t;

    // Gain read selection
    typedef struct packed {
        logic [IDX_W-1:0] in_idx;
        logic [IDX_W-1:0] out_idx;
    } gain_rd_t;

endpackage : amm_pkg

`default_nettype wire

// File: rtl/audio_matrix_mixer.sv
// ============================================================================
// audio_matrix_mixer - matrix audio mixer with input and output gains
// Sequencer, accumulators and stream ports around one shared multiplier.
// ============================================================================
// A gain-write beat is taken in the idle state and goes straight to the gain
// bank. A sample beat for a present input takes one multiply for the
// input gain, then a multiply and an accumulate for each output, all on the
// single 32x16 multiplier; no new beat is taken until it is through. A beat
// with tlast then adds a multiply and an emit for each output (outputs 0..7
// at most) plus any stall on m_tready; the last result may sit in the output
// register while the next beat is taken. After reset the crosspoint RAM is
// zeroed by a sweep over its min(INPUTS,8)*min(OUTPUTS,8) entries, during
// which s_tready is low. Gains are unsigned with GAIN_FRAC_BITS fraction bits;
// every product is floored, accumulators saturate at 32 bits and mixed samples at 24 bits.
`default_nettype none

module audio_matrix_mixer
    import amm_pkg::*;
#(
    parameter int INPUTS         = 8,
    parameter int OUTPUTS        = 8,
    parameter int GAIN_FRAC_BITS = 14
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input stream
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    // in_index[2:0], out_index[5:3], gain_value[21:6], sample[45:22], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // func[0], gain_kind[2:1]
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    // end_of_frame
    input  wire logic                 s_tlast,
    // result stream
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // out_channel[2:0], mixed_sample[26:3], zero pad
    output      logic [M_TDATA_W-1:0] m_tdata,
    // last
    output      logic                 m_tlast
);

    localparam int NI = (INPUTS < MAX_CH) ? INPUTS : MAX_CH;
    localparam int NO = (OUTPUTS < MAX_CH) ? OUTPUTS : MAX_CH;
    localparam int IW = (NI > 1) ? $clog2(NI) : 1;
    localparam int OW = (NO > 1) ? $clog2(NO) : 1;

    // ------------------------------------------------------------------
    // Input beat fields
    // ------------------------------------------------------------------
    logic                       s_func;
    logic [1:0]                 s_kind;
    logic [IDX_W-1:0]           s_in_idx;
    logic [IDX_W-1:0]           s_out_idx;
    logic [GAIN_W-1:0]          s_gain;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic                       s_accept;
    logic                       s_in_ok;

    assign s_func    = s_tuser[0];
    assign s_kind    = s_tuser[2:1];
    assign s_in_idx  = s_tdata[2:0];
    assign s_out_idx = s_tdata[5:3];
    assign s_gain    = s_tdata[21:6];
    assign s_sample  = $signed(s_tdata[45:22]);
    assign s_accept  = s_tvalid && s_tready;
    assign s_in_ok   = int'(s_in_idx) < NI;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    amm_state_t                 state_reg, state_next;
    logic signed [SAMPLE_W-1:0] smp_reg;
    logic [IW-1:0]              ich_reg;
    logic                       eof_reg;
    logic [OW-1:0]              o_cnt_reg, o_cnt_next;
    logic signed [MUL_A_W-1:0]  scaled_reg;
    logic signed [ACC_W-1:0]    acc_reg [NO];

    logic                       m_tvalid_reg;
    logic [IDX_W-1:0]           out_chan_reg;
    logic signed [SAMPLE_W-1:0] out_smp_reg;
    logic                       out_last_reg;

    logic                       clr_busy;
    logic                       o_last;
    logic                       out_load;

    // ------------------------------------------------------------------
    // Shared multiplier and gain bank
    // ------------------------------------------------------------------
    logic                       mul_en;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic [GAIN_W-1:0]          mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_sh;

    gain_wr_t                   gain_wr;
    gain_rd_t                   gain_rd;
    logic [GAIN_W-1:0]          in_gain;
    logic [GAIN_W-1:0]          out_gain;
    logic [GAIN_W-1:0]          xp_gain;
    logic [OW-1:0]              rd_o;

    amm_mul_unit u_mul (
        .aclk     (aclk),
        .en       (mul_en),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    amm_gain_bank #(
        .NI             (NI),
        .NO             (NO),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_gain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr           (gain_wr),
        .rd           (gain_rd),
        .in_gain      (in_gain),
        .out_gain     (out_gain),
        .xp_gain_reg  (xp_gain),
        .clr_busy_reg (clr_busy)
    );

    assign o_last   = (o_cnt_reg == OW'(NO - 1));
    assign out_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign prod_sh  = prod >>> GAIN_FRAC_BITS;

    // Gain write straight from the accepted beat
    always_comb begin
        gain_wr.en      = s_accept && (s_func == FUNC_GAIN);
        gain_wr.kind    = s_kind;
        gain_wr.in_idx  = s_in_idx;
        gain_wr.out_idx = s_out_idx;
        gain_wr.value   = s_gain;
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        o_cnt_next = o_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                o_cnt_next = '0;
                if (s_accept && (s_func == FUNC_SAMPLE)) begin
                    if (s_in_ok) begin
                        state_next = ST_SCALE;
                    end else if (s_tlast) begin
                        state_next = ST_OMUL;
                    end
                end
            end
            ST_SCALE: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_XMUL;
            ST_XMUL:  state_next = ST_XACC;
            ST_XACC: begin
                if (o_last) begin
                    o_cnt_next = '0;
                    state_next = eof_reg ? ST_OMUL : ST_IDLE;
                end else begin
                    o_cnt_next = o_cnt_reg + 1'b1;
                    state_next = ST_XMUL;
                end
            end
            ST_OMUL:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_load) begin
                    if (o_last) begin
                        o_cnt_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        o_cnt_next = o_cnt_reg + 1'b1;
                        state_next = ST_OMUL;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath controls
    // ------------------------------------------------------------------
    always_comb begin
        mul_en = 1'b0;
        mul_a  = scaled_reg;
        mul_b  = xp_gain;
        rd_o   = '0;
        unique case (state_reg)
            ST_SCALE: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(smp_reg);
                mul_b  = in_gain;
            end
            ST_XMUL: begin
                mul_en = 1'b1;
            end
            ST_XACC: begin
                // prefetch next crosspoint gain
                rd_o = o_cnt_reg + 1'b1;
            end
            ST_OMUL: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(acc_reg[o_cnt_reg]);
                mul_b  = out_gain;
                rd_o   = o_cnt_reg;
            end
            ST_EMIT: begin
                rd_o = o_cnt_reg;
            end
            default: begin
                rd_o = '0;
            end
        endcase
        gain_rd.in_idx  = IDX_W'(ich_reg);
        gain_rd.out_idx = IDX_W'(rd_o);
    end

    // Accumulate with 32-bit saturation
    logic signed [PROD_W:0]    acc_sum;
    logic signed [ACC_W-1:0]   acc_new;
    logic                      acc_fits;

    always_comb begin
        acc_sum  = (PROD_W + 1)'(acc_reg[o_cnt_reg]) + (PROD_W + 1)'(prod_sh);
        acc_fits = (acc_sum[PROD_W:ACC_W-1] == '0) || (acc_sum[PROD_W:ACC_W-1] == '1);
        if (acc_fits) begin
            acc_new = acc_sum[ACC_W-1:0];
        end else if (acc_sum[PROD_W]) begin
            acc_new = {1'b1, {(ACC_W - 1){1'b0}}};
        end else begin
            acc_new = {1'b0, {(ACC_W - 1){1'b1}}};
        end
    end

    // Output scaling with 24-bit saturation
    logic signed [SAMPLE_W-1:0] mix_new;
    logic                       mix_fits;

    always_comb begin
        mix_fits = (prod_sh[PROD_W-1:SAMPLE_W-1] == '0)
                || (prod_sh[PROD_W-1:SAMPLE_W-1] == '1);
        if (mix_fits) begin
            mix_new = prod_sh[SAMPLE_W-1:0];
        end else if (prod_sh[PROD_W-1]) begin
            mix_new = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        end else begin
            mix_new = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            o_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            o_cnt_reg <= o_cnt_next;
        end
    end

    // capture of the sample beat
    always_ff @(posedge aclk) begin
        if (s_accept && (s_func == FUNC_SAMPLE)) begin
            smp_reg <= s_sample;
            ich_reg <= s_in_idx[IW-1:0];
            eof_reg <= s_tlast;
        end
        if (state_reg == ST_LOAD) begin
            scaled_reg <= prod_sh[MUL_A_W-1:0];
        end
    end

    // accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NO; k++) begin
                acc_reg[k] <= '0;
            end
        end else if (state_reg == ST_XACC) begin
            acc_reg[o_cnt_reg] <= acc_new;
        end else if (out_load && o_last) begin
            for (int k = 0; k < NO; k++) begin
                acc_reg[k] <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_chan_reg <= IDX_W'(o_cnt_reg);
            out_smp_reg  <= mix_new;
            out_last_reg <= o_last;
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !clr_busy;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - IDX_W - SAMPLE_W){1'b0}}, out_smp_reg, out_chan_reg};
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result beat raised outside emit");

    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && o_last) |=> (acc_reg[0] == '0))
        else $error("accumulators not cleared at frame end");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(o_cnt_reg) < NO)
        else $error("output counter out of range");

    a_scale_valid_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCALE) |-> (int'(ich_reg) < NI))
        else $error("mixing an absent input");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> (state_reg == ST_IDLE) && !s_accept)
        else $error("beat taken during crosspoint clear");

endmodule : audio_matrix_mixer

`default_nettype wire

// File: rtl/amm_mul_unit.sv
// ============================================================================
// amm_mul_unit - shared multiplier of the mixer
// Signed operand times unsigned gain, product registered when enabled.
// ============================================================================
`default_nettype none

module amm_mul_unit
    import amm_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic signed [MUL_A_W-1:0] a,
    input  wire logic        [GAIN_W-1:0]  b,
    output      logic signed [PROD_W-1:0]  prod_reg
);

    logic signed [PROD_W-1:0] prod_next;

    // gain is zero-extended so the product stays signed
    always_comb begin
        prod_next = a * $signed({1'b0, b});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

endmodule : amm_mul_unit

`default_nettype wire

// File: rtl/amm_gain_bank.sv
// ============================================================================
// amm_gain_bank - gain storage of the mixer
// Input and output gains in flops (reset to unity), crosspoint gains in a
// small RAM that is zeroed by a clearing sweep after reset.
// ============================================================================
`default_nettype none

module amm_gain_bank
    import amm_pkg::*;
#(
    parameter int NI             = 8,
    parameter int NO             = 8,
    parameter int GAIN_FRAC_BITS = 14
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire gain_wr_t          wr,
    input  wire gain_rd_t          rd,
    output      logic [GAIN_W-1:0] in_gain,
    output      logic [GAIN_W-1:0] out_gain,
    output      logic [GAIN_W-1:0] xp_gain_reg,
    output      logic              clr_busy_reg
);

    localparam int XP_DEPTH = NI * NO;
    localparam int XA_W     = (XP_DEPTH > 1) ? $clog2(XP_DEPTH) : 1;
    localparam int IW       = (NI > 1) ? $clog2(NI) : 1;
    localparam int OW       = (NO > 1) ? $clog2(NO) : 1;
    localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1 << GAIN_FRAC_BITS);

    logic [GAIN_W-1:0] ig_reg [NI];
    logic [GAIN_W-1:0] og_reg [NO];
    logic [GAIN_W-1:0] xp_mem [XP_DEPTH];

    logic [XA_W-1:0] clr_addr_reg;
    logic [XA_W-1:0] clr_addr_next;
    logic            clr_busy_next;

    logic            in_ok;
    logic            out_ok;
    logic            wr_ig;
    logic            wr_og;
    logic            wr_xp;
    logic [XA_W-1:0] xp_waddr;
    logic [XA_W-1:0] xp_raddr;

    // Write decode: out-of-range channels and the unused kind are dropped
    always_comb begin
        in_ok  = int'(wr.in_idx) < NI;
        out_ok = int'(wr.out_idx) < NO;
        wr_ig  = 1'b0;
        wr_og  = 1'b0;
        wr_xp  = 1'b0;
        case (wr.kind)
            KIND_INPUT:  wr_ig = wr.en && in_ok;
            KIND_XPOINT: wr_xp = wr.en && in_ok && out_ok;
            KIND_OUTPUT: wr_og = wr.en && out_ok;
            default:     wr_ig = 1'b0;
        endcase
    end

    assign xp_waddr = XA_W'(int'(wr.in_idx) * NO + int'(wr.out_idx));
    assign xp_raddr = XA_W'(int'(rd.in_idx) * NO + int'(rd.out_idx));

    // Input and output gain registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NI; i++) begin
                ig_reg[i] <= UNITY;
            end
            for (int j = 0; j < NO; j++) begin
                og_reg[j] <= UNITY;
            end
        end else begin
            if (wr_ig) begin
                ig_reg[wr.in_idx[IW-1:0]] <= wr.value;
            end
            if (wr_og) begin
                og_reg[wr.out_idx[OW-1:0]] <= wr.value;
            end
        end
    end

    assign in_gain  = ig_reg[rd.in_idx[IW-1:0]];
    assign out_gain = og_reg[rd.out_idx[OW-1:0]];

    // Clearing sweep over the crosspoint RAM after reset
    always_comb begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            if (clr_addr_reg == XA_W'(XP_DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end else begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // Crosspoint RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            xp_mem[clr_addr_reg] <= '0;
        end else if (wr_xp) begin
            xp_mem[xp_waddr] <= wr.value;
        end
    end

    always_ff @(posedge aclk) begin
        xp_gain_reg <= xp_mem[xp_raddr];
    end

endmodule : amm_gain_bank

`default_nettype wire
